// ----- rtl/rtl_pkg.sv -----
`default_nettype none
package rtl_pkg;

  localparam int unsigned ModeW    = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned IndexW   = 12;
  localparam int unsigned BaseW    = 12;
  localparam int unsigned CountW   = 11;
  localparam int unsigned YesW     = 11;
  localparam int unsigned NoW      = 10;
  localparam int unsigned QnumW    = 8;
  localparam int unsigned KindW    = 6;
  localparam int unsigned WordW    = 32;
  localparam int unsigned TreesCfgW = 5;
  localparam int unsigned QuesCfgW = 9;
  localparam int unsigned CfgW     = 9;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [ModeW-1:0] ModeTree  = 3'd0;
  localparam logic [ModeW-1:0] ModeNode  = 3'd1;
  localparam logic [ModeW-1:0] ModeQues  = 3'd2;
  localparam logic [ModeW-1:0] ModePool  = 3'd3;
  localparam logic [ModeW-1:0] ModeFeat  = 3'd4;
  localparam logic [ModeW-1:0] ModeWalk  = 3'd5;

  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StOob    = 2'd1;
  localparam logic [StatusW-1:0] StFormat = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgTrees = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgQues  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;      // apply a load beat to the tables
    logic start;      // latch tree header, node := 0
    logic rd_node;    // read node tables at current address
    logic rd_ques;    // read question table entry
    logic scan_start; // set scan position to value set base, read feature value
    logic scan_rd;    // read pool at scan position, advance
    logic take_yes;
    logic take_no;
  } rtl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tree_oob;
    logic tree_empty;
    logic node_bad;   // node index or address out of range
    logic is_leaf;
    logic ques_bad;   // question number or value set out of range
    logic scan_done;  // no more pool entries to read
    logic hit;        // registered pool word equals feature value
  } rtl_sts_t;

endpackage
`default_nettype wire

// ----- rtl/rtl_ctrl.sv -----
`default_nettype none
module rtl_ctrl
  import rtl_pkg::*;
#(
  parameter int unsigned STEP_LIMIT = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ModeW-1:0]   mode_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [StatusW-1:0]      status_o,
  output logic                    load_leaf_o,
  output rtl_cmd_t                cmd_o,
  input  rtl_sts_t                sts_i
);

  localparam int unsigned StepW = $clog2(STEP_LIMIT + 1);

  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SHead  = 8'b00000010,
    SNode  = 8'b00000100,
    SCheck = 8'b00001000,
    SQues  = 8'b00010000,
    SScan  = 8'b00100000,
    SCmp   = 8'b01000000,
    SOut   = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [StepW-1:0] steps_q, steps_d;
  logic [StatusW-1:0] status_q, status_d;
  logic load_leaf;

  logic accept;
  assign in_ready_o  = (state_q == SIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == SOut);
  assign status_o    = status_q;
  assign load_leaf_o = load_leaf;

  always_comb begin
    state_d  = state_q;
    steps_d  = steps_q;
    status_d = status_q;
    cmd_o    = '0;
    load_leaf = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          if (mode_i == ModeWalk) begin
            cmd_o.start = 1'b1;
            steps_d = '0;
            state_d = SHead;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      SHead: begin
        if (sts_i.tree_oob) begin
          status_d = StOob;
          state_d = SOut;
        end else if (sts_i.tree_empty) begin
          status_d = StFormat;
          state_d = SOut;
        end else begin
          state_d = SNode;
        end
      end
      SNode: begin
        if (steps_q == StepW'(STEP_LIMIT) || sts_i.node_bad) begin
          status_d = StFormat;
          state_d = SOut;
        end else begin
          cmd_o.rd_node = 1'b1;
          steps_d = steps_q + 1'b1;
          state_d = SCheck;
        end
      end
      SCheck: begin
        if (sts_i.is_leaf) begin
          load_leaf = 1'b1;
          status_d = StOk;
          state_d = SOut;
        end else begin
          cmd_o.rd_ques = 1'b1;
          state_d = SQues;
        end
      end
      SQues: begin
        if (sts_i.ques_bad) begin
          status_d = StFormat;
          state_d = SOut;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = SScan;
        end
      end
      SScan: begin
        if (sts_i.scan_done) begin
          cmd_o.take_no = 1'b1;
          state_d = SNode;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d = SCmp;
        end
      end
      SCmp: begin
        if (sts_i.hit) begin
          cmd_o.take_yes = 1'b1;
          state_d = SNode;
        end else begin
          state_d = SScan;
        end
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      steps_q  <= '0;
      status_q <= StOk;
    end else begin
      state_q  <= state_d;
      steps_q  <= steps_d;
      status_q <= status_d;
    end
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= StepW'(STEP_LIMIT)) else $error("step counter overrun");
  a_walk_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == ModeWalk) |=> state_q == SHead)
    else $error("traverse not started");
`endif

endmodule
`default_nettype wire

// ----- rtl/rtl_dp.sv -----
`default_nettype none
module rtl_dp
  import rtl_pkg::*;
#(
  parameter int unsigned MAX_TREES     = 16,
  parameter int unsigned NODE_STORE    = 1024,
  parameter int unsigned MAX_QUESTIONS = 256,
  parameter int unsigned VALUE_POOL    = 4096,
  parameter int unsigned FEATURE_KINDS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [ModeW-1:0]     mode_i,
  input  wire logic [IndexW-1:0]    index_i,
  input  wire logic [BaseW-1:0]     base_i,
  input  wire logic [CountW-1:0]    count_i,
  input  wire logic [YesW-1:0]      yes_link_i,
  input  wire logic [NoW-1:0]       no_link_i,
  input  wire logic [QnumW-1:0]     question_number_i,
  input  wire logic [KindW-1:0]     feature_kind_i,
  input  wire logic [WordW-1:0]     word_i,
  input  wire logic [WordW-1:0]     leaf_mean_bits_i,
  input  wire logic [WordW-1:0]     leaf_var_bits_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgW-1:0]      cfg_data_i,
  input  wire logic                 load_leaf_i,
  input  wire logic                 ok_i,
  output logic [WordW-1:0]          mean_bits_o,
  output logic [WordW-1:0]          var_bits_o,
  input  rtl_cmd_t                  cmd_i,
  output rtl_sts_t                  sts_o
);

  localparam int unsigned TrW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam int unsigned NdW = (NODE_STORE > 1) ? $clog2(NODE_STORE) : 1;
  localparam int unsigned QsW = (MAX_QUESTIONS > 1) ? $clog2(MAX_QUESTIONS) : 1;
  localparam int unsigned PlW = (VALUE_POOL > 1) ? $clog2(VALUE_POOL) : 1;
  localparam int unsigned FkW = (FEATURE_KINDS > 1) ? $clog2(FEATURE_KINDS) : 1;
  localparam int unsigned LinkW = YesW + NoW + QnumW;
  localparam int unsigned QEntW = KindW + BaseW + CountW;

  // Tree headers reset to zero; small enough for flip-flops.
  logic [BaseW-1:0]  tree_base_q [MAX_TREES];
  logic [CountW-1:0] tree_cnt_q  [MAX_TREES];
  logic [LinkW-1:0]  link_mem [NODE_STORE];
  logic [2*WordW-1:0] leaf_mem [NODE_STORE];
  logic [QEntW-1:0]  ques_mem [MAX_QUESTIONS];
  logic [WordW-1:0]  pool_mem [VALUE_POOL];
  logic [WordW-1:0]  feat_mem [FEATURE_KINDS];

  logic [TreesCfgW-1:0] trees_in_use_q;
  logic [QuesCfgW-1:0]  ques_in_use_q;

  logic [IndexW-1:0] tree_q;
  logic [BaseW-1:0]  t_base_q;
  logic [CountW-1:0] t_cnt_q;
  logic [NoW:0]      node_q;
  logic [LinkW-1:0]  link_q;
  logic [2*WordW-1:0] leaf_q;
  logic [QEntW-1:0]  ques_q;
  logic              kind_ok_q;
  logic [WordW-1:0]  feat_q;
  logic [BaseW:0]    scan_pos_q;
  logic [BaseW:0]    scan_end_q;
  logic [WordW-1:0]  pool_q;
  logic              cmp_q;
  logic [WordW-1:0]  mean_q, var_q;

  logic [YesW-1:0]  yes_w;
  logic [NoW-1:0]   no_w;
  logic [QnumW-1:0] qn_w;
  assign {yes_w, no_w, qn_w} = link_q;

  logic [KindW-1:0]  q_kind;
  logic [BaseW-1:0]  q_base;
  logic [CountW-1:0] q_cnt;
  assign {q_kind, q_base, q_cnt} = ques_q;

  logic [BaseW+1:0] node_addr;
  assign node_addr = (BaseW+2)'(t_base_q) + (BaseW+2)'(node_q);

  // One bit wider than the base so a set that runs past the pool is seen.
  logic [BaseW:0] q_end;
  assign q_end = {1'b0, q_base} + (BaseW+1)'(q_cnt);

  logic tree_hit;
  assign tree_hit = ({20'd0, tree_q} < 32'(MAX_TREES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trees_in_use_q <= '0;
      ques_in_use_q  <= '0;
      for (int i = 0; i < MAX_TREES; i++) begin
        tree_base_q[i] <= '0;
        tree_cnt_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgTrees: trees_in_use_q <= cfg_data_i[TreesCfgW-1:0];
          CfgQues:  ques_in_use_q  <= cfg_data_i[QuesCfgW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.write && mode_i == ModeTree && 32'(index_i) < 32'(MAX_TREES)) begin
        tree_base_q[index_i[TrW-1:0]] <= base_i;
        tree_cnt_q[index_i[TrW-1:0]]  <= count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      case (mode_i)
        ModeNode: if (32'(index_i) < 32'(NODE_STORE)) begin
          link_mem[index_i[NdW-1:0]] <= {yes_link_i, no_link_i, question_number_i};
          leaf_mem[index_i[NdW-1:0]] <= {leaf_mean_bits_i, leaf_var_bits_i};
        end
        ModeQues: if (32'(index_i) < 32'(MAX_QUESTIONS))
          ques_mem[index_i[QsW-1:0]] <= {feature_kind_i, base_i, count_i};
        ModePool: if (32'(index_i) < 32'(VALUE_POOL))
          pool_mem[index_i[PlW-1:0]] <= word_i;
        ModeFeat: if (32'(feature_kind_i) < 32'(FEATURE_KINDS))
          feat_mem[feature_kind_i[FkW-1:0]] <= word_i;
        default: ;
      endcase
    end
    if (cmd_i.start) begin
      tree_q   <= index_i;
      node_q   <= '0;
      t_base_q <= tree_base_q[index_i[TrW-1:0]];
      t_cnt_q  <= tree_cnt_q[index_i[TrW-1:0]];
    end
    if (cmd_i.rd_node) begin
      link_q <= link_mem[node_addr[NdW-1:0]];
      leaf_q <= leaf_mem[node_addr[NdW-1:0]];
    end
    if (cmd_i.rd_ques) begin
      ques_q <= ques_mem[qn_w[QsW-1:0] & QnumW'((1 << QsW) - 1)];
    end
    if (cmd_i.scan_start) begin
      scan_pos_q <= {1'b0, q_base};
      scan_end_q <= q_end;
      kind_ok_q  <= 32'(q_kind) < 32'(FEATURE_KINDS);
      feat_q     <= feat_mem[q_kind[FkW-1:0]];
    end
    if (cmd_i.scan_rd) begin
      pool_q     <= pool_mem[scan_pos_q[PlW-1:0]];
      scan_pos_q <= scan_pos_q + 1'b1;
    end
    if (cmd_i.take_yes) node_q <= yes_w;
    if (cmd_i.take_no)  node_q <= {1'b0, no_w};
    if (load_leaf_i) begin
      {mean_q, var_q} <= leaf_q;
    end
  end

  // Compare in the cycle after the pool read so the read stays registered.
  always_comb cmp_q = (pool_q == (kind_ok_q ? feat_q : '0));

  assign sts_o.tree_oob   = !tree_hit ||
                            ({20'd0, tree_q} >= {27'd0, trees_in_use_q});
  assign sts_o.tree_empty = (t_cnt_q == '0);
  assign sts_o.node_bad   = ({1'b0, node_q} >= {1'b0, t_cnt_q}) ||
                            (32'(node_addr) >= 32'(NODE_STORE));
  assign sts_o.is_leaf    = yes_w[YesW-1];
  assign sts_o.ques_bad   = ({1'b0, qn_w} >= ques_in_use_q) ||
                            (32'(qn_w) >= 32'(MAX_QUESTIONS)) ||
                            (32'(q_end) > 32'(VALUE_POOL));
  assign sts_o.scan_done  = (scan_pos_q >= scan_end_q);
  assign sts_o.hit        = cmp_q;

  assign mean_bits_o = ok_i ? mean_q : '0;
  assign var_bits_o  = ok_i ? var_q : '0;

endmodule
`default_nettype wire

// ----- rtl/regression_tree_lookup_top.sv -----
// Channel  Dir  Fields
// s_axis   in   tdata: mode, index, base, count, yes_link, no_link, question_number,
//                      feature_kind, word, leaf_mean_bits, leaf_var_bits
// m_axis   out  tdata: status, mean_bits, var_bits
// cfg      in   we, idx (0 trees_in_use, 1 questions_in_use), data
// A load beat is written in its accept cycle. A traverse latches the tree header,
// then per branch level reads the node, the question and the feature value, and scans
// the value set entry by entry to a hit or its end; at the leaf it loads the result.
// No beat is accepted until the result is taken. Loads and walks share the datapath.
// Reset clears control, config and tree headers; the rest holds garbage until written.
// The result holds in the output register while m_axis_tready is low.
`default_nettype none
module regression_tree_lookup_top
  import rtl_pkg::*;
#(
  parameter int unsigned MAX_TREES     = 16,
  parameter int unsigned NODE_STORE    = 1024,
  parameter int unsigned MAX_QUESTIONS = 256,
  parameter int unsigned VALUE_POOL    = 4096,
  parameter int unsigned FEATURE_KINDS = 64,
  parameter int unsigned STEP_LIMIT    = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // mode[2:0] index[14:3] base[26:15] count[37:27] yes_link[48:38] no_link[58:49]
  // question_number[66:59] feature_kind[72:67] word[104:73] leaf_mean_bits[136:105]
  // leaf_var_bits[168:137], zeros above
  input  wire logic [175:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[1:0] mean_bits[33:2] var_bits[65:34], zeros above
  output logic [71:0]       m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  rtl_cmd_t cmd;
  rtl_sts_t sts;
  logic [StatusW-1:0] status;
  logic load_leaf;
  logic [WordW-1:0] mean_bits, var_bits;

  rtl_ctrl #(.STEP_LIMIT(STEP_LIMIT)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .mode_i(s_axis_tdata[2:0]),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_o(status), .load_leaf_o(load_leaf),
    .cmd_o(cmd), .sts_i(sts)
  );

  rtl_dp #(
    .MAX_TREES(MAX_TREES), .NODE_STORE(NODE_STORE), .MAX_QUESTIONS(MAX_QUESTIONS),
    .VALUE_POOL(VALUE_POOL), .FEATURE_KINDS(FEATURE_KINDS)
  ) u_dp (
    .clk_i, .rst_ni,
    .mode_i(s_axis_tdata[2:0]),
    .index_i(s_axis_tdata[14:3]),
    .base_i(s_axis_tdata[26:15]),
    .count_i(s_axis_tdata[37:27]),
    .yes_link_i(s_axis_tdata[48:38]),
    .no_link_i(s_axis_tdata[58:49]),
    .question_number_i(s_axis_tdata[66:59]),
    .feature_kind_i(s_axis_tdata[72:67]),
    .word_i(s_axis_tdata[104:73]),
    .leaf_mean_bits_i(s_axis_tdata[136:105]),
    .leaf_var_bits_i(s_axis_tdata[168:137]),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .load_leaf_i(load_leaf),
    .ok_i(status == StOk),
    .mean_bits_o(mean_bits), .var_bits_o(var_bits),
    .cmd_i(cmd), .sts_o(sts)
  );

  assign m_axis_tdata = {6'd0, var_bits, mean_bits, status};

endmodule
`default_nettype wire

// ----- bench/regression_tree_lookup_checker.sv -----
`default_nettype none
module regression_tree_lookup_checker
  import rtl_pkg::*;
#(
  parameter int unsigned MAX_TREES     = 16,
  parameter int unsigned NODE_STORE    = 1024,
  parameter int unsigned MAX_QUESTIONS = 256,
  parameter int unsigned VALUE_POOL    = 4096,
  parameter int unsigned FEATURE_KINDS = 64,
  parameter int unsigned STEP_LIMIT    = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  input  wire logic               s_axis_tready,
  input  wire logic [175:0]       s_axis_tdata,
  input  wire logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  input  wire logic [71:0]        m_axis_tdata,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [BaseW-1:0]  tree_first [MAX_TREES];
  logic [CountW-1:0] tree_count [MAX_TREES];
  logic [YesW-1:0]   node_yes   [NODE_STORE];
  logic [NoW-1:0]    node_no    [NODE_STORE];
  logic [QnumW-1:0]  node_ques  [NODE_STORE];
  logic [WordW-1:0]  node_mean  [NODE_STORE];
  logic [WordW-1:0]  node_var   [NODE_STORE];
  logic [KindW-1:0]  ques_kind  [MAX_QUESTIONS];
  logic [BaseW-1:0]  ques_first [MAX_QUESTIONS];
  logic [CountW-1:0] ques_count [MAX_QUESTIONS];
  logic [WordW-1:0]  pool       [VALUE_POOL];
  logic [WordW-1:0]  feature    [FEATURE_KINDS];
  logic [TreesCfgW-1:0] trees_cfg;
  logic [QuesCfgW-1:0]  ques_cfg;

  // Each entry is {var_bits, mean_bits, status}.
  logic [65:0] leaf_answers [$];

  assign pending_o = leaf_answers.size();

  function automatic logic [65:0] walk_tree(logic [IndexW-1:0] tree);
    int unsigned node, addr, qn, kind, first, cnt;
    logic [WordW-1:0] fv;
    logic hit;
    if (tree >= trees_cfg || tree >= MAX_TREES) return {64'd0, StOob};
    if (tree_count[tree] == 0) return {64'd0, StFormat};
    node = 0;
    for (int steps = 0; steps < STEP_LIMIT; steps++) begin
      if (node >= tree_count[tree]) return {64'd0, StFormat};
      addr = tree_first[tree] + node;
      if (addr >= NODE_STORE) return {64'd0, StFormat};
      if (node_yes[addr][YesW-1]) return {node_var[addr], node_mean[addr], StOk};
      qn = node_ques[addr];
      if (qn >= ques_cfg || qn >= MAX_QUESTIONS) return {64'd0, StFormat};
      kind = ques_kind[qn];
      fv = (kind < FEATURE_KINDS) ? feature[kind] : '0;
      first = ques_first[qn];
      cnt = ques_count[qn];
      if (first + cnt > VALUE_POOL) return {64'd0, StFormat};
      hit = 1'b0;
      for (int i = 0; i < cnt; i++) if (pool[first + i] == fv) hit = 1'b1;
      node = hit ? node_yes[addr] : node_no[addr];
    end
    return {64'd0, StFormat};
  endfunction

  initial begin
    fail_count_o = 0;
    trees_cfg = '0;
    ques_cfg = '0;
    foreach (tree_count[i]) begin
      tree_first[i] = '0;
      tree_count[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    logic [2:0] mode;
    logic [11:0] ix;
    logic [65:0] want;
    mode = s_axis_tdata[2:0];
    ix = s_axis_tdata[14:3];
    if (!rst_ni) begin
      trees_cfg = '0;
      ques_cfg = '0;
      foreach (tree_count[i]) begin
        tree_first[i] = '0;
        tree_count[i] = '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgTrees) trees_cfg = cfg_data_i[TreesCfgW-1:0];
        else if (cfg_idx_i == CfgQues) ques_cfg = cfg_data_i[QuesCfgW-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (leaf_answers.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected result beat: %h", m_axis_tdata[65:0]);
          fail_count_o++;
        end else begin
          want = leaf_answers.pop_front();
          if (m_axis_tdata[1:0] !== want[1:0] || m_axis_tdata[33:2] !== want[33:2] ||
              m_axis_tdata[65:34] !== want[65:34]) begin
            if (fail_count_o < 10)
              $display("mismatch: status %0d/%0d mean %h/%h var %h/%h (exp/got)",
                       want[1:0], m_axis_tdata[1:0], want[33:2], m_axis_tdata[33:2],
                       want[65:34], m_axis_tdata[65:34]);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (mode)
          ModeTree: if (ix < MAX_TREES) begin
            tree_first[ix] = s_axis_tdata[26:15];
            tree_count[ix] = s_axis_tdata[37:27];
          end
          ModeNode: if (ix < NODE_STORE) begin
            node_yes[ix]  = s_axis_tdata[48:38];
            node_no[ix]   = s_axis_tdata[58:49];
            node_ques[ix] = s_axis_tdata[66:59];
            node_mean[ix] = s_axis_tdata[136:105];
            node_var[ix]  = s_axis_tdata[168:137];
          end
          ModeQues: if (ix < MAX_QUESTIONS) begin
            ques_kind[ix]  = s_axis_tdata[72:67];
            ques_first[ix] = s_axis_tdata[26:15];
            ques_count[ix] = s_axis_tdata[37:27];
          end
          ModePool: if (ix < VALUE_POOL) pool[ix] = s_axis_tdata[104:73];
          ModeFeat: if (s_axis_tdata[72:67] < FEATURE_KINDS)
            feature[s_axis_tdata[72:67]] = s_axis_tdata[104:73];
          ModeWalk: leaf_answers.push_back(walk_tree(ix));
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none
module testbench
  import rtl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgTrees;
  logic [CfgW-1:0] cfg_data_i = '0;
  int fail_count, pending, cycles = 0;
  int snd_idle = 38, rcv_idle = 68;
  int trees_now = 0, ques_now = 0, sent;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  regression_tree_lookup_top DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  regression_tree_lookup_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [175:0] pack(logic [2:0] m, logic [11:0] ix, logic [11:0] b,
                                        logic [10:0] c, logic [10:0] y, logic [9:0] n,
                                        logic [7:0] q, logic [5:0] k, logic [31:0] w,
                                        logic [31:0] mn, logic [31:0] vr);
    return {7'd0, vr, mn, w, k, q, n, y, c, b, ix, m};
  endfunction

  // Small alphabet so that feature values often land in a value set.
  function automatic logic [31:0] pick_word();
    return ($urandom_range(0, 99) < 75) ? 32'($urandom_range(0, 7)) : $urandom;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send(logic [175:0] d);
    while ($urandom_range(0, 99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic put_tree(int t, int b, int c);
    send(pack(ModeTree, t, b, c, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic put_node(int a, logic [10:0] y, int n, int q, logic [31:0] mn,
                          logic [31:0] vr);
    send(pack(ModeNode, a, $urandom, $urandom, y, n, q, $urandom, $urandom, mn, vr));
  endtask

  task automatic put_ques(int ix, int k, int b, int c);
    send(pack(ModeQues, ix, b, c, 0, 0, 0, k, 0, 0, 0));
  endtask

  task automatic put_pool(int ix, logic [31:0] w);
    send(pack(ModePool, ix, 0, 0, 0, 0, 0, 0, w, 0, 0));
  endtask

  task automatic put_feat(int k, logic [31:0] w);
    send(pack(ModeFeat, 0, 0, 0, 0, 0, 0, k, w, 0, 0));
  endtask

  task automatic walk(int t);
    send(pack(ModeWalk, t, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom));
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] ix, int v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= ix;
    cfg_data_i <= CfgW'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (ix == CfgTrees) trees_now = v;
    else ques_now = v;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic build_tree();
    int t, n, b, y, no, q;
    t = $urandom_range(0, 15);
    n = $urandom_range(1, 20);
    b = $urandom_range(0, 1023);
    put_tree(t, b, n);
    for (int i = 0; i < n; i++) begin
      q = ($urandom_range(0, 99) < 5 || ques_now == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, ques_now - 1);
      if (i == n - 1 || $urandom_range(0, 99) < 35) begin
        put_node(b + i, {1'b1, 10'($urandom)}, $urandom_range(0, 1023), q, $urandom,
                 $urandom);
      end else begin
        y = $urandom_range(i + 1, n - 1);
        no = ($urandom_range(0, 99) < 5) ? $urandom_range(0, n + 1)
                                         : $urandom_range(i + 1, n - 1);
        put_node(b + i, y, no, q, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int r, noise_mode, c;
    logic [175:0] d;
    sent = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Right after reset no tree is in use.
    walk(0);
    settle();
    write_reg(CfgTrees, 16);
    write_reg(CfgQues, 256);

    // Value sets that are scanned lie in the low 256 pool entries or at 4095, so filling those,
    // the feature store and the question table covers every read of a walk.
    // Nodes are only reached through trees whose nodes were written first.
    for (int i = 0; i < 256; i++) put_pool(i, pick_word());
    put_pool(4095, pick_word());
    for (int i = 0; i < 64; i++) put_feat(i, pick_word());
    for (int i = 0; i < 256; i++) begin
      c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 8);
      put_ques(i, $urandom_range(0, 63), $urandom_range(0, 255 - c), c);
    end

    // Directed cases.
    put_tree(0, 5, 0);
    walk(0);
    put_node(1020, 11'h7FF, 1023, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_tree(15, 1020, 1);
    walk(15);
    walk(16);
    walk(4095);
    put_ques(250, 63, 4090, 64);
    put_ques(251, 1, 0, 1);
    put_ques(252, 2, 4095, 1);
    put_feat(1, 32'hFFFF_FFFF);
    put_pool(0, 32'hFFFF_FFFF);
    put_node(1000, 1, 2, 251, 0, 0);
    put_node(1001, 11'h400, 0, 0, 0, 0);
    put_node(1002, 11'h400, 0, 0, 32'hFFFF_FFFF, 32'h1234_5678);
    put_tree(14, 1000, 3);
    walk(14);
    // A node that points back at itself runs into the step limit.
    put_node(1003, 0, 0, 251, 0, 0);
    put_tree(13, 1003, 1);
    walk(13);
    put_node(1004, 5, 5, 251, 0, 0);
    put_tree(12, 1004, 2);
    walk(12);
    put_node(1005, 0, 0, 250, 0, 0);
    put_tree(11, 1005, 1);
    walk(11);
    put_node(1023, 1, 1, 252, 0, 0);
    put_tree(10, 1023, 2);
    walk(10);
    // A full-size tree whose root is a leaf; the tree is emptied afterwards.
    put_node(0, 11'h400, 0, 0, 32'hCAFE_0001, 32'h0000_BEEF);
    put_tree(8, 0, 1024);
    walk(8);
    put_tree(8, 0, 0);
    send(pack(ModeTree, 4095, 4095, 2047, 0, 0, 0, 0, 0, 0, 0));
    send(pack(ModeNode, 1024, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(pack(ModeQues, 256, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(pack(3'd6, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0, 0, 0, 0));
    send(pack(3'd7, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0, 0, 0, 0));

    // Random phases, each under the register setting written at its start.
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin write_reg(CfgTrees, 16); write_reg(CfgQues, 256); end
        1: begin write_reg(CfgTrees, 7); write_reg(CfgQues, 128); end
        2: begin write_reg(CfgTrees, 1); write_reg(CfgQues, 1); end
        3: begin write_reg(CfgTrees, 0); write_reg(CfgQues, 0); end
        default: begin write_reg(CfgTrees, 16); write_reg(CfgQues, 256); end
      endcase
      snd_idle = (ph < 2) ? 38 : (ph < 4) ? 68 : 0;
      rcv_idle = (ph < 2) ? 68 : (ph < 4) ? 38 : 0;
      sent = 0;
      while (sent < 110) begin
        r = $urandom_range(0, 99);
        if (r < 10) build_tree();
        else if (r < 20)
          put_ques($urandom_range(0, 255), $urandom_range(0, 63), $urandom_range(0, 247),
                   $urandom_range(0, 8));
        else if (r < 35) put_feat($urandom_range(0, 63), pick_word());
        else if (r < 42) put_pool($urandom_range(0, 255), pick_word());
        else if (r < 50) begin
          noise_mode = $urandom_range(0, 7);
          d = pack(noise_mode, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
          if (noise_mode == ModeQues) begin
            c = $urandom_range(0, 64);
            d[37:27] = 11'(c);
            d[26:15] = 12'($urandom_range(0, 255 - c));
          end
          // Random tree headers would point at unwritten nodes; keep them out of range.
          if (noise_mode == ModeTree) d[14:3] = 12'($urandom_range(16, 4095));
          send(d);
        end else walk(($urandom_range(0, 9) == 0) ? $urandom_range(16, 4095)
                                                    : $urandom_range(0, 15));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
